[hw/rtl/apq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg - shared definitions for the announcement priority queue
// Queue geometry, status and opcode codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package apq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH      = 8;
   localparam int IDX_BITS         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int TEXT_HANDLE_BITS = 16;

   // Fixed field widths
   localparam int NODE_BITS   = 32;
   localparam int URG_BITS    = 2;
   localparam int AGE_BITS    = 32;
   localparam int DROP_BITS   = 4;
   localparam int STATUS_BITS = 2;

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes (word address)
   localparam logic REG_READER_EN = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   // Opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_TEXT = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   // Lowest slot whose valid bit is clear
   function automatic logic [IDX_BITS-1:0] first_free(input logic [QUEUE_DEPTH-1:0] valid);
      logic [IDX_BITS-1:0] pick;
      pick = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            pick = IDX_BITS'(i);
         end
      end
      return pick;
   endfunction

endpackage

[hw/rtl/announcement_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// announcement_priority_queue - bounded urgency/age ordered message queue
// Fixed-depth queue of announcements with preemption of low-urgency entries
// and overflow eviction of the oldest entry; one scan unit serves every slot.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | beat contents
//  ---------+-----------+------------------------+------------------------------
//  req_     | in        | req_valid / req_ready  | opcode, node, urgency, text
//  rsp_     | out       | rsp_valid / rsp_ready  | status, node, urgency, text, drops
//  csr      | in/out    | psel, penable, pready  | reader enable, high threshold
//
//  A pop or an enabled push steps from the accept in idle through the scan,
//  one slot per cycle through the shared compare unit, to a commit state and
//  a result state. Refused or discarded pushes go from idle straight to result.
//  The result register lets a new beat be taken while the last result waits;
//  a finished item holds in the result state until that register frees.
//  Reset is synchronous and clears all valid bits, the sequence counter and
//  the registers; slot contents are not cleared.
// ----------------------------------------------------------------------------
module announcement_priority_queue
   import apq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [NODE_BITS-1:0]         req_node_ref,
   input  logic [URG_BITS-1:0]          req_urgency,
   input  logic [TEXT_HANDLE_BITS-1:0]  req_payload,
   input  logic                         req_has_text,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [NODE_BITS-1:0]         rsp_out_node,
   output logic [URG_BITS-1:0]          rsp_out_urgency,
   output logic [TEXT_HANDLE_BITS-1:0]  rsp_out_payload,
   output logic [DROP_BITS-1:0]         rsp_dropped,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   localparam int ENTRY_BITS = NODE_BITS + TEXT_HANDLE_BITS;

   // Configuration registers
   logic                reader_en_ff;
   logic [URG_BITS-1:0] thr_ff;
   logic                csr_wr;

   // Sequencer and captured request
   state_type                   state_ff, state_in;
   logic [IDX_BITS-1:0]         idx_ff, idx_in;
   logic                        pop_ff;
   logic [NODE_BITS-1:0]        node_ff;
   logic [URG_BITS-1:0]         urg_ff;
   logic [TEXT_HANDLE_BITS-1:0] text_ff;
   logic                        preempt_ff;

   // Scan tracking
   logic                found_ff, found_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [URG_BITS-1:0] best_urg_ff, best_urg_in;
   logic [AGE_BITS-1:0] best_dist_ff, best_dist_in;
   logic [DROP_BITS-1:0] drop_ff, drop_in;
   status_type          status_ff, status_in;
   logic                hit_ff, hit_in;

   // Slot state
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [URG_BITS-1:0]    slot_urg_ff [QUEUE_DEPTH];
   logic [AGE_BITS-1:0]    slot_age_ff [QUEUE_DEPTH];
   logic [ENTRY_BITS-1:0]  slot_mem    [QUEUE_DEPTH];
   logic [ENTRY_BITS-1:0]  rd_data_ff;
   logic [AGE_BITS-1:0]    seq_ff, seq_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff;
   logic [NODE_BITS-1:0]        rsp_node_ff;
   logic [URG_BITS-1:0]         rsp_urg_ff;
   logic [TEXT_HANDLE_BITS-1:0] rsp_text_ff;
   logic [DROP_BITS-1:0]        rsp_drop_ff;

   // Shared scan unit signals
   logic                scan_valid;
   logic [URG_BITS-1:0] scan_urg;
   logic [AGE_BITS-1:0] scan_dist;
   logic                scan_older;
   logic                scan_kill;
   logic                scan_take;
   logic                scan_last;

   // Commit signals
   logic                full;
   logic [IDX_BITS-1:0] wr_idx;
   logic                slot_wr;
   logic                mem_rd;
   logic                req_take;
   logic                rsp_load;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         reader_en_ff <= 1'b0;
         thr_ff       <= URG_BITS'(2);
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_READER_EN: reader_en_ff <= pwdata[0];
            REG_THRESHOLD: thr_ff       <= pwdata[URG_BITS-1:0];
            default:       reader_en_ff <= reader_en_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_READER_EN: prdata = {{(CSR_DATA_BITS-1){1'b0}}, reader_en_ff};
         REG_THRESHOLD: prdata = {{(CSR_DATA_BITS-URG_BITS){1'b0}}, thr_ff};
         default:       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Shared compare unit: one slot per cycle
   // ------------------------------------------------------------------------
   assign scan_valid = valid_ff[idx_ff];
   assign scan_urg   = slot_urg_ff[idx_ff];
   assign scan_dist  = seq_ff - slot_age_ff[idx_ff];
   assign scan_older = scan_dist > best_dist_ff;
   assign scan_last  = (idx_ff == IDX_BITS'(QUEUE_DEPTH - 1));
   assign scan_kill  = !pop_ff && preempt_ff && scan_valid && (scan_urg < thr_ff);

   always_comb begin
      if (pop_ff) begin
         scan_take = scan_valid && (!found_ff || (scan_urg > best_urg_ff) ||
                                    ((scan_urg == best_urg_ff) && scan_older));
      end else begin
         scan_take = scan_valid && !scan_kill && (!found_ff || scan_older);
      end
   end

   assign full     = &valid_ff;
   assign wr_idx   = full ? best_idx_ff : first_free(valid_ff);
   assign req_take = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
   assign slot_wr  = (state_ff == ST_COMMIT) && !pop_ff;
   assign mem_rd   = (state_ff == ST_COMMIT) && pop_ff;

   // ------------------------------------------------------------------------
   // Sequencer next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_urg_in  = best_urg_ff;
      best_dist_in = best_dist_ff;
      drop_in      = drop_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      valid_in     = valid_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;

      // release the result register on a taken beat
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idx_in       = '0;
               found_in     = 1'b0;
               best_dist_in = '0;
               best_urg_in  = '0;
               drop_in      = '0;
               hit_in       = 1'b0;
               status_in    = STATUS_OK;
               if (req_opcode == OP_POP) begin
                  state_in = ST_SCAN;
               end else if (!req_has_text) begin
                  status_in = STATUS_NO_TEXT;
                  state_in  = ST_RESULT;
               end else if (!reader_en_ff) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // drop preempted slots, track best or oldest survivor
            if (scan_kill) begin
               valid_in[idx_ff] = 1'b0;
               drop_in = (drop_ff == '1) ? drop_ff : drop_ff + DROP_BITS'(1);
            end
            if (scan_take) begin
               found_in     = 1'b1;
               best_idx_in  = idx_ff;
               best_urg_in  = scan_urg;
               best_dist_in = scan_dist;
            end
            idx_in = idx_ff + IDX_BITS'(1);
            if (scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (pop_ff) begin
               if (found_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
                  hit_in = 1'b1;
               end else begin
                  status_in = STATUS_EMPTY;
               end
            end else begin
               // evict the oldest when full, then store the new entry
               if (full) begin
                  drop_in = (drop_ff == '1) ? drop_ff : drop_ff + DROP_BITS'(1);
               end
               valid_in[wr_idx] = 1'b1;
               seq_in = seq_ff + AGE_BITS'(1);
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_urg_ff  <= best_urg_in;
      best_dist_ff <= best_dist_in;
      drop_ff      <= drop_in;
      status_ff    <= status_in;
      hit_ff       <= hit_in;
      if (req_take) begin
         pop_ff     <= (req_opcode == OP_POP);
         node_ff    <= req_node_ref;
         urg_ff     <= req_urgency;
         text_ff    <= req_payload;
         preempt_ff <= (req_urgency >= thr_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Slot storage: urgency and age in registers, node and text in memory
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_urg_ff[wr_idx] <= urg_ff;
         slot_age_ff[wr_idx] <= seq_ff + AGE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_mem[wr_idx] <= {node_ff, text_ff};
      end
      if (mem_rd) begin
         rd_data_ff <= slot_mem[best_idx_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_drop_ff   <= drop_ff;
         if (hit_ff) begin
            rsp_node_ff <= rd_data_ff[ENTRY_BITS-1:TEXT_HANDLE_BITS];
            rsp_text_ff <= rd_data_ff[TEXT_HANDLE_BITS-1:0];
            rsp_urg_ff  <= best_urg_ff;
         end else begin
            rsp_node_ff <= '0;
            rsp_text_ff <= '0;
            rsp_urg_ff  <= '0;
         end
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_node    = rsp_node_ff;
   assign rsp_out_urgency = rsp_urg_ff;
   assign rsp_out_payload = rsp_text_ff;
   assign rsp_dropped     = rsp_drop_ff;

endmodule

[tb/announcement_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// announcement_priority_queue_tb - self-checking bench for the announcement queue
// Request beats come from a queue of pending announcements and are driven on
// the falling edge. Every accepted beat runs through a behavioural copy of the
// urgency/age ordered store, and each reply beat is checked field by field
// against the oldest prediction. The bench runs directed corner cases first,
// then random traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module announcement_priority_queue_tb;
   import apq_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = QUEUE_DEPTH + 6;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 60;

   typedef struct packed {
      logic                        opcode;
      logic [NODE_BITS-1:0]        node;
      logic [URG_BITS-1:0]         urgency;
      logic [TEXT_HANDLE_BITS-1:0] text;
      logic                        has_text;
   } announce_req_type;

   typedef struct packed {
      status_type                  status;
      logic [NODE_BITS-1:0]        node;
      logic [URG_BITS-1:0]         urgency;
      logic [TEXT_HANDLE_BITS-1:0] text;
      logic [DROP_BITS-1:0]        dropped;
   } announce_rsp_type;

   // Clock, reset and block pins
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_opcode = OP_PUSH;
   logic [NODE_BITS-1:0]        req_node_ref = '0;
   logic [URG_BITS-1:0]         req_urgency = '0;
   logic [TEXT_HANDLE_BITS-1:0] req_payload = '0;
   logic                        req_has_text = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]      rsp_status;
   logic [NODE_BITS-1:0]        rsp_out_node;
   logic [URG_BITS-1:0]         rsp_out_urgency;
   logic [TEXT_HANDLE_BITS-1:0] rsp_out_payload;
   logic [DROP_BITS-1:0]        rsp_dropped;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]    paddr = '0;
   logic [CSR_DATA_BITS-1:0]    pwdata = '0;
   logic [CSR_DATA_BITS-1:0]    prdata;
   logic                        pready;

   // Bench state
   announce_req_type outgoing_requests[$];
   announce_rsp_type announcement_replies[$];
   logic          req_accepted = 1'b0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            fault_count = 0;
   int            cycle_count = 0;

   // Mirror of the queue and its registers
   logic                        reader_on = 1'b0;
   logic [URG_BITS-1:0]         high_mark = 2'd2;
   logic                        held_valid [QUEUE_DEPTH];
   logic [URG_BITS-1:0]         held_urg   [QUEUE_DEPTH];
   logic [AGE_BITS-1:0]         held_age   [QUEUE_DEPTH];
   logic [NODE_BITS-1:0]        held_node  [QUEUE_DEPTH];
   logic [TEXT_HANDLE_BITS-1:0] held_text  [QUEUE_DEPTH];
   int                          held_count = 0;
   logic [AGE_BITS-1:0]         stamp = '0;

   announcement_priority_queue dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_node_ref    (req_node_ref),
      .req_urgency     (req_urgency),
      .req_payload     (req_payload),
      .req_has_text    (req_has_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_node    (rsp_out_node),
      .rsp_out_urgency (rsp_out_urgency),
      .rsp_out_payload (rsp_out_payload),
      .rsp_dropped     (rsp_dropped),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         held_valid[i] = 1'b0;
         held_urg[i]   = '0;
         held_age[i]   = '0;
         held_node[i]  = '0;
         held_text[i]  = '0;
      end
   end

   // Distance back to an entry's stamp, modulo the counter width
   function automatic logic [AGE_BITS-1:0] age_gap(int slot);
      return stamp - held_age[slot];
   endfunction

   // Apply one announcement to the mirror and return the reply it causes
   function automatic announce_rsp_type serve_announcement(announce_req_type r);
      announce_rsp_type rep;
      int            i;
      int            best;
      int            free_slot;
      int            drops;
      rep.status  = STATUS_OK;
      rep.node    = '0;
      rep.urgency = '0;
      rep.text    = '0;
      rep.dropped = '0;
      drops       = 0;
      if (r.opcode == OP_POP) begin
         // most urgent first, oldest among equals
         best = -1;
         for (i = 0; i < QUEUE_DEPTH; i++) begin
            if (held_valid[i] && (best < 0 || held_urg[i] > held_urg[best] ||
                (held_urg[i] == held_urg[best] && age_gap(i) > age_gap(best)))) begin
               best = i;
            end
         end
         if (best < 0) begin
            rep.status = STATUS_EMPTY;
         end else begin
            rep.node          = held_node[best];
            rep.urgency       = held_urg[best];
            rep.text          = held_text[best];
            held_valid[best]  = 1'b0;
            if (held_count > 0) held_count--;
         end
      end else if (!r.has_text) begin
         rep.status = STATUS_NO_TEXT;
      end else if (reader_on) begin
         // drop lower-urgency entries on an urgent push
         if (r.urgency >= high_mark) begin
            for (i = 0; i < QUEUE_DEPTH; i++) begin
               if (held_valid[i] && held_urg[i] < high_mark) begin
                  held_valid[i] = 1'b0;
                  if (held_count > 0) held_count--;
                  drops++;
               end
            end
         end
         // evict the oldest entry when full
         if (held_count >= QUEUE_DEPTH) begin
            best = -1;
            for (i = 0; i < QUEUE_DEPTH; i++) begin
               if (held_valid[i] && (best < 0 || age_gap(i) > age_gap(best))) begin
                  best = i;
               end
            end
            if (best >= 0) begin
               held_valid[best] = 1'b0;
               drops++;
            end
            held_count--;
         end
         // store in the lowest free slot
         free_slot = -1;
         for (i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!held_valid[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            stamp                 = stamp + AGE_BITS'(1);
            held_valid[free_slot] = 1'b1;
            held_node[free_slot]  = r.node;
            held_urg[free_slot]   = r.urgency;
            held_age[free_slot]   = stamp;
            held_text[free_slot]  = r.text;
            held_count++;
         end
         rep.dropped = (drops > 15) ? 4'd15 : DROP_BITS'(drops);
      end
      return rep;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: reply %s mismatch, got %0h, want %0h", $time, what, got, want);
      fault_count++;
   endtask

   task automatic add_request(logic op, logic [NODE_BITS-1:0] node,
                              logic [URG_BITS-1:0] urg,
                              logic [TEXT_HANDLE_BITS-1:0] text, logic has_text);
      announce_req_type r;
      r.opcode   = op;
      r.node     = node;
      r.urgency  = urg;
      r.text     = text;
      r.has_text = has_text;
      outgoing_requests.push_back(r);
   endtask

   task automatic add_random_request(int pop_pct);
      logic op;
      op = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
      add_request(op, $urandom, URG_BITS'($urandom_range(3)),
                  TEXT_HANDLE_BITS'($urandom), $urandom_range(99) >= 8);
   endtask

   // Hold until every beat is sent and answered, then let the block go idle
   task automatic settle();
      while (outgoing_requests.size() != 0 || req_valid ||
             announcement_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup then access cycle; the register takes the value on the access edge
   task automatic write_register(logic idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == REG_READER_EN) begin
         reader_on = value[0];
      end else begin
         high_mark = value[URG_BITS-1:0];
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Request driver: advance to the next beat only once the current one is taken
   always @(negedge clock) begin : request_driver
      announce_req_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (outgoing_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = outgoing_requests.pop_front();
            req_valid    <= 1'b1;
            req_opcode   <= beat.opcode;
            req_node_ref <= beat.node;
            req_urgency  <= beat.urgency;
            req_payload  <= beat.text;
            req_has_text <= beat.has_text;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Reply back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Predict on each request beat, check each reply beat
   always @(posedge clock) begin : reply_monitor
      announce_req_type taken;
      announce_rsp_type want;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            taken.opcode   = req_opcode;
            taken.node     = req_node_ref;
            taken.urgency  = req_urgency;
            taken.text     = req_payload;
            taken.has_text = req_has_text;
            announcement_replies.push_back(serve_announcement(taken));
         end
         if (rsp_valid && rsp_ready) begin
            if (announcement_replies.size() == 0) begin
               flag_mismatch("beat (none pending)", 32'(rsp_status), 32'd0);
            end else begin
               want = announcement_replies.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_out_node !== want.node)
                  flag_mismatch("node", rsp_out_node, want.node);
               if (rsp_out_urgency !== want.urgency)
                  flag_mismatch("urgency", 32'(rsp_out_urgency), 32'(want.urgency));
               if (rsp_out_payload !== want.text)
                  flag_mismatch("payload", 32'(rsp_out_payload), 32'(want.text));
               if (rsp_dropped !== want.dropped)
                  flag_mismatch("dropped", 32'(rsp_dropped), 32'(want.dropped));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("announcement_priority_queue verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      int pop_pct;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reader off after reset: pushes are taken but nothing is stored
      add_request(OP_POP, $urandom, 2'd3, 16'hFFFF, 1'b1);
      add_request(OP_PUSH, 32'h1234_5678, 2'd1, 16'h00AA, 1'b0);
      add_request(OP_PUSH, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 1'b1);
      add_request(OP_POP, '0, '0, '0, 1'b0);
      settle();

      // Reader on: preemption, filling, overflow, empty text, pops
      write_register(REG_READER_EN, 32'd1);
      write_register(REG_THRESHOLD, 32'd2);
      add_request(OP_PUSH, '0, 2'd0, '0, 1'b1);
      add_request(OP_PUSH, 32'hFFFF_FFFF, 2'd1, 16'hFFFF, 1'b1);
      add_request(OP_PUSH, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 1'b1);
      for (n = 0; n < QUEUE_DEPTH - 1; n++) begin
         add_request(OP_PUSH, $urandom, 2'd2, TEXT_HANDLE_BITS'($urandom), 1'b1);
      end
      add_request(OP_PUSH, $urandom, 2'd2, TEXT_HANDLE_BITS'($urandom), 1'b1);
      add_request(OP_PUSH, 32'hDEAD_BEEF, 2'd0, '0, 1'b0);
      add_request(OP_POP, $urandom, 2'd1, 16'h5A5A, 1'b0);
      add_request(OP_POP, '0, '0, '0, 1'b1);
      settle();

      // Random traffic under changing settings and idle patterns
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_register(REG_READER_EN, (phase == 4) ? 32'd0 : 32'd1);
         write_register(REG_THRESHOLD, phase % 4);
         pop_pct = 20 + 15 * (phase % 3);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // pause the sender halfway until the queue has answered everything
            if (n == ITEMS_PER_PHASE / 2) settle();
            add_random_request(pop_pct);
         end
         settle();
      end

      if (fault_count == 0) begin
         $display("announcement_priority_queue verification clean");
      end else begin
         $display("announcement_priority_queue verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/apq_pkg.sv
hw/rtl/announcement_priority_queue.sv
tb/announcement_priority_queue_tb.sv
